// ===== rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg: shared constants for the arc-from-chord unit
// CORDIC datapath widths, Q6.30 angle constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

    // Datapath width of the CORDIC x/y lanes and of the Q6.30 angle lane
    localparam int CW = 40;
    localparam int ZW = 36;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;

    // 1/K of the CORDIC gain, Q0.29
    localparam logic [29:0] GAIN_INV_Q29 = 30'd326016437;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned k);
        return $signed({{(ZW-30){1'b0}}, ATAN_Q30[k[4:0]]});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/acr_cordic.sv =====
// ----------------------------------------------------------------------------
// acr_cordic: pipelined shift-add CORDIC
// One pre-rotation stage then one micro-rotation per stage. VECTOR selects
// vectoring (drive y to zero, accumulate angle) or rotation (drive z to zero).
// ----------------------------------------------------------------------------
`default_nettype none

module acr_cordic #(
    parameter int STAGES = 16,
    parameter int TW     = 8,
    parameter bit VECTOR = 1'b1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [acr_pkg::CW-1:0] i_x,
    input  logic signed [acr_pkg::CW-1:0] i_y,
    input  logic signed [acr_pkg::ZW-1:0] i_z,
    input  logic [TW-1:0]                 i_tag,
    output logic                          o_valid,
    output logic signed [acr_pkg::CW-1:0] o_x,
    output logic signed [acr_pkg::CW-1:0] o_y,
    output logic signed [acr_pkg::ZW-1:0] o_z,
    output logic [TW-1:0]                 o_tag
);
    import acr_pkg::*;

    logic signed [CW-1:0] r_x   [0:STAGES];
    logic signed [CW-1:0] r_y   [0:STAGES];
    logic signed [ZW-1:0] r_z   [0:STAGES];
    logic [TW-1:0]        r_tag [0:STAGES];
    logic [STAGES:0]      r_zero;
    logic [STAGES:0]      r_valid;

    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_zero0;

    // Pre-rotation: fold the vector or the angle into the right half plane
    always_comb begin
        n_x0    = i_x;
        n_y0    = i_y;
        n_z0    = '0;
        n_zero0 = 1'b0;
        if (VECTOR) begin
            n_zero0 = (i_x == '0) && (i_y == '0);
            if (i_x[CW-1]) begin
                n_z0 = i_y[CW-1] ? -PI_Q30 : PI_Q30;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end
        end else begin
            n_z0 = i_z;
            if (i_z > HALF_PI_Q30) begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = i_z - HALF_PI_Q30;
            end else if (i_z < -HALF_PI_Q30) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = i_z + HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= n_zero0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 n_cw;
        logic signed [CW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            // clockwise step: in vectoring when y > 0, in rotation when z < 0
            n_cw = VECTOR ? (!r_y[k][CW-1] && (r_y[k] != '0)) : r_z[k][ZW-1];
            if (n_cw) begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + atan_q30(k);
            end else begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_zero[k+1] <= r_zero[k];
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_valid = r_valid[STAGES];
    assign o_x     = r_zero[STAGES] ? '0 : r_x[STAGES];
    assign o_y     = r_y[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_tag   = r_tag[STAGES];

endmodule

`default_nettype wire

// ===== rtl/arc_from_chord_and_radius_unit.sv =====
// ----------------------------------------------------------------------------
// arc_from_chord_and_radius_unit: arc centre, angles and length from a chord
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken. The depth is set by three CORDIC pipelines
// and a 32-step digit-by-digit square root. Synchronous active-low reset
// clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_from_chord_and_radius_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_signed_radius,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [15:0] o_entry_angle,
    output logic signed [15:0] o_exit_angle,
    output logic signed [15:0] o_sweep_angle,
    output logic [31:0]        o_arc_length,
    output logic               o_counter_clockwise,
    output logic               o_chord_too_long
);
    import acr_pkg::*;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [31:0]        ar;
        logic               ccw;
    } t_tag1;

    typedef struct packed {
        t_tag1 base;
        logic  too_long;
    } t_tag2;

    typedef struct packed {
        logic signed [ZW-1:0] th;
        t_tag2                t;
    } t_tagq;

    typedef struct packed {
        logic signed [35:0] cx2;
        logic signed [35:0] cy2;
        logic [31:0]        ar;
        logic               ccw;
        logic               too_long;
    } t_tag3;

    localparam int SQ = 32;

    function automatic logic [15:0] to_q13(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = z + ZW'(65536);
        return 16'(t >>> 17);
    endfunction

    logic en;
    logic r_o_valid;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    // ---------------- stage A: chord vector, |r| ----------------
    logic                 r_a_valid;
    logic signed [CW-1:0] r_a_dx, r_a_dy;
    t_tag1                r_a_tag;
    t_tag1                n_a_tag;

    always_comb begin
        n_a_tag.sx  = i_start_x;
        n_a_tag.sy  = i_start_y;
        n_a_tag.ex  = i_end_x;
        n_a_tag.ey  = i_end_y;
        n_a_tag.ar  = i_signed_radius[31] ? (32'd0 - i_signed_radius) : i_signed_radius;
        n_a_tag.ccw = !i_signed_radius[31] && (i_signed_radius != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx  <= CW'(i_end_x) - CW'(i_start_x);
            r_a_dy  <= CW'(i_end_y) - CW'(i_start_y);
            r_a_tag <= n_a_tag;
        end
    end

    // ---------------- chord direction and length ----------------
    logic                 c1_valid;
    logic signed [CW-1:0] c1_x;
    logic signed [ZW-1:0] c1_z;
    t_tag1                c1_tag;

    acr_cordic #(
        .STAGES (CORDIC_STAGES),
        .TW     ($bits(t_tag1)),
        .VECTOR (1'b1)
    ) u_cordic_chord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_valid),
        .i_x     (r_a_dx),
        .i_y     (r_a_dy),
        .i_z     ('0),
        .i_tag   (r_a_tag),
        .o_valid (c1_valid),
        .o_x     (c1_x),
        .o_y     (),
        .o_z     (c1_z),
        .o_tag   (c1_tag)
    );

    // ---------------- stage B: gain removal product ----------------
    logic                 r_b_valid;
    logic [64:0]          r_b_hp;
    logic signed [ZW-1:0] r_b_th;
    t_tag1                r_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_hp  <= c1_x[34:0] * GAIN_INV_Q29;
            r_b_th  <= c1_z;
            r_b_tag <= c1_tag;
        end
    end

    // ---------------- stage C: half chord, range check ----------------
    logic        r_c_valid;
    logic [31:0] r_c_diff;
    logic [32:0] r_c_sum;
    t_tagq       r_c_tag;
    logic [64:0] n_c_hs;
    logic [34:0] n_c_h;

    assign n_c_hs = r_b_hp + 65'd536870912;
    assign n_c_h  = n_c_hs[64:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_diff            <= r_b_tag.ar - n_c_h[31:0];
            r_c_sum             <= 33'(r_b_tag.ar) + 33'(n_c_h[31:0]);
            r_c_tag.th          <= r_b_th;
            r_c_tag.t.base      <= r_b_tag;
            r_c_tag.t.too_long  <= n_c_h > 35'(r_b_tag.ar);
        end
    end

    // ---------------- stage D: (|r| - h) * (|r| + h) ----------------
    logic        r_d_valid;
    logic [63:0] r_d_prod;
    t_tagq       r_d_tag;
    logic [64:0] n_d_prod;

    assign n_d_prod = r_c_diff * r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_prod <= n_d_prod[63:0];
            r_d_tag  <= r_c_tag;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [63:0] r_q_v    [1:SQ];
    logic [35:0] r_q_rem  [1:SQ];
    logic [31:0] r_q_root [1:SQ];
    t_tagq       r_q_tag  [1:SQ];
    logic [SQ:1] r_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= '0;
        end else if (en) begin
            r_q_valid <= {r_q_valid[SQ-1:1], r_d_valid};
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        logic [63:0] n_v;
        logic [35:0] n_rem;
        logic [31:0] n_root;
        t_tagq       n_tag;
        logic [35:0] n_pre;
        logic [35:0] n_trial;

        if (j == 0) begin : g_first
            assign n_v    = r_d_prod;
            assign n_rem  = '0;
            assign n_root = '0;
            assign n_tag  = r_d_tag;
        end else begin : g_next
            assign n_v    = r_q_v[j];
            assign n_rem  = r_q_rem[j];
            assign n_root = r_q_root[j];
            assign n_tag  = r_q_tag[j];
        end

        assign n_pre   = {n_rem[33:0], n_v[63:62]};
        assign n_trial = {2'b00, n_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_v[j+1]   <= {n_v[61:0], 2'b00};
                r_q_tag[j+1] <= n_tag;
                if (n_pre >= n_trial) begin
                    r_q_rem[j+1]  <= n_pre - n_trial;
                    r_q_root[j+1] <= {n_root[30:0], 1'b1};
                end else begin
                    r_q_rem[j+1]  <= n_pre;
                    r_q_root[j+1] <= {n_root[30:0], 1'b0};
                end
            end
        end
    end

    // ---------------- rotate centre offset by the chord direction ----------
    logic signed [CW-1:0] q_norm;
    logic signed [CW-1:0] q_offy;
    logic                 c2_valid;
    logic signed [CW-1:0] c2_x, c2_y;
    t_tag2                c2_tag;

    assign q_norm = $signed({{(CW-32){1'b0}}, r_q_root[SQ]});
    assign q_offy = r_q_tag[SQ].t.base.ccw ? q_norm : -q_norm;

    acr_cordic #(
        .STAGES (CORDIC_STAGES),
        .TW     ($bits(t_tag2)),
        .VECTOR (1'b0)
    ) u_cordic_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_q_valid[SQ]),
        .i_x     ('0),
        .i_y     (q_offy),
        .i_z     (r_q_tag[SQ].th),
        .i_tag   (r_q_tag[SQ].t),
        .o_valid (c2_valid),
        .o_x     (c2_x),
        .o_y     (c2_y),
        .o_z     (),
        .o_tag   (c2_tag)
    );

    // ---------------- stage E: offset gain products ----------------
    logic               r_e_valid;
    logic signed [65:0] r_e_px, r_e_py;
    t_tag2              r_e_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_px  <= $signed(c2_x[34:0]) * $signed({1'b0, GAIN_INV_Q29});
            r_e_py  <= $signed(c2_y[34:0]) * $signed({1'b0, GAIN_INV_Q29});
            r_e_tag <= c2_tag;
        end
    end

    // ---------------- stage F: round offset ----------------
    logic               r_f_valid;
    logic signed [33:0] r_f_offx, r_f_offy;
    t_tag2              r_f_tag;
    logic signed [65:0] n_f_rx, n_f_ry;

    assign n_f_rx = r_e_px + 66'sd268435456;
    assign n_f_ry = r_e_py + 66'sd268435456;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_offx <= $signed(n_f_rx[62:29]);
            r_f_offy <= $signed(n_f_ry[62:29]);
            r_f_tag  <= r_e_tag;
        end
    end

    // ---------------- stage G: centre at doubled resolution ----------------
    logic               r_g_valid;
    logic signed [35:0] r_g_cx2, r_g_cy2;
    t_tag2              r_g_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_cx2 <= 36'(r_f_tag.base.sx) + 36'(r_f_tag.base.ex) + (36'(r_f_offx) <<< 1);
            r_g_cy2 <= 36'(r_f_tag.base.sy) + 36'(r_f_tag.base.ey) + (36'(r_f_offy) <<< 1);
            r_g_tag <= r_f_tag;
        end
    end

    // ---------------- stage H: vectors from centre to end points -----------
    logic                 r_h_valid;
    logic signed [CW-1:0] r_h_ax, r_h_ay, r_h_bx, r_h_by;
    t_tag3                r_h_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_ax           <= (CW'(r_g_tag.base.sx) <<< 1) - CW'(r_g_cx2);
            r_h_ay           <= (CW'(r_g_tag.base.sy) <<< 1) - CW'(r_g_cy2);
            r_h_bx           <= (CW'(r_g_tag.base.ex) <<< 1) - CW'(r_g_cx2);
            r_h_by           <= (CW'(r_g_tag.base.ey) <<< 1) - CW'(r_g_cy2);
            r_h_tag.cx2      <= r_g_cx2;
            r_h_tag.cy2      <= r_g_cy2;
            r_h_tag.ar       <= r_g_tag.base.ar;
            r_h_tag.ccw      <= r_g_tag.base.ccw;
            r_h_tag.too_long <= r_g_tag.too_long;
        end
    end

    // ---------------- start and end angles ----------------
    logic                 c3_valid;
    logic signed [ZW-1:0] c3_za, c3_zb;
    t_tag3                c3_tag;

    acr_cordic #(
        .STAGES (CORDIC_STAGES),
        .TW     ($bits(t_tag3)),
        .VECTOR (1'b1)
    ) u_cordic_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_valid),
        .i_x     (r_h_ax),
        .i_y     (r_h_ay),
        .i_z     ('0),
        .i_tag   (r_h_tag),
        .o_valid (c3_valid),
        .o_x     (),
        .o_y     (),
        .o_z     (c3_za),
        .o_tag   (c3_tag)
    );

    acr_cordic #(
        .STAGES (CORDIC_STAGES),
        .TW     (1),
        .VECTOR (1'b1)
    ) u_cordic_end (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_valid),
        .i_x     (r_h_bx),
        .i_y     (r_h_by),
        .i_z     ('0),
        .i_tag   (1'b0),
        .o_valid (),
        .o_x     (),
        .o_y     (),
        .o_z     (c3_zb),
        .o_tag   ()
    );

    // ---------------- stage I: sweep wrap, centre rounding ----------------
    logic                 r_i_valid;
    logic signed [ZW-1:0] r_i_za, r_i_zb, r_i_sw;
    logic signed [31:0]   r_i_cx, r_i_cy;
    logic [31:0]          r_i_ar;
    logic                 r_i_ccw, r_i_too_long;
    logic signed [ZW:0]   n_i_d;
    logic signed [ZW:0]   n_i_sw;
    logic signed [35:0]   n_i_cx, n_i_cy;
    logic signed [31:0]   n_i_cxs, n_i_cys;

    always_comb begin
        n_i_d = (ZW+1)'(c3_zb) - (ZW+1)'(c3_za);
        if (n_i_d > (ZW+1)'(PI_Q30)) begin
            n_i_sw = n_i_d - (ZW+1)'(TWO_PI_Q30);
        end else if (n_i_d < -(ZW+1)'(PI_Q30)) begin
            n_i_sw = n_i_d + (ZW+1)'(TWO_PI_Q30);
        end else begin
            n_i_sw = n_i_d;
        end

        n_i_cx = (c3_tag.cx2 + 36'sd1) >>> 1;
        n_i_cy = (c3_tag.cy2 + 36'sd1) >>> 1;
        if (n_i_cx > 36'sd2147483647) begin
            n_i_cxs = 32'sh7fffffff;
        end else if (n_i_cx < -36'sd2147483648) begin
            n_i_cxs = 32'sh80000000;
        end else begin
            n_i_cxs = n_i_cx[31:0];
        end
        if (n_i_cy > 36'sd2147483647) begin
            n_i_cys = 32'sh7fffffff;
        end else if (n_i_cy < -36'sd2147483648) begin
            n_i_cys = 32'sh80000000;
        end else begin
            n_i_cys = n_i_cy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (en) begin
            r_i_valid <= c3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_za       <= c3_za;
            r_i_zb       <= c3_zb;
            r_i_sw       <= n_i_sw[ZW-1:0];
            r_i_cx       <= n_i_cxs;
            r_i_cy       <= n_i_cys;
            r_i_ar       <= c3_tag.ar;
            r_i_ccw      <= c3_tag.ccw;
            r_i_too_long <= c3_tag.too_long;
        end
    end

    // ---------------- stage J: |sweep| * |r|, angle narrowing ----------------
    logic                 r_j_valid;
    logic [66:0]          r_j_prod;
    logic [15:0]          r_j_qa, r_j_qb, r_j_qs;
    logic signed [31:0]   r_j_cx, r_j_cy;
    logic                 r_j_ccw, r_j_too_long;
    logic signed [ZW-1:0] n_j_abs;

    assign n_j_abs = r_i_sw[ZW-1] ? -r_i_sw : r_i_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (en) begin
            r_j_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_prod     <= n_j_abs[ZW-2:0] * r_i_ar;
            r_j_qa       <= to_q13(r_i_za);
            r_j_qb       <= to_q13(r_i_zb);
            r_j_qs       <= to_q13(r_i_sw);
            r_j_cx       <= r_i_cx;
            r_j_cy       <= r_i_cy;
            r_j_ccw      <= r_i_ccw;
            r_j_too_long <= r_i_too_long;
        end
    end

    // ---------------- output register ----------------
    logic [66:0] n_o_ls;
    logic [31:0] n_o_len;

    assign n_o_ls  = r_j_prod + 67'd536870912;
    assign n_o_len = (|n_o_ls[66:62]) ? 32'hffffffff : n_o_ls[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_counter_clockwise <= r_j_ccw;
            o_chord_too_long    <= r_j_too_long;
            if (r_j_too_long) begin
                o_center_x    <= '0;
                o_center_y    <= '0;
                o_entry_angle <= '0;
                o_exit_angle  <= '0;
                o_sweep_angle <= '0;
                o_arc_length  <= '0;
            end else begin
                o_center_x    <= r_j_cx;
                o_center_y    <= r_j_cy;
                o_entry_angle <= r_j_qa;
                o_exit_angle  <= r_j_qb;
                o_sweep_angle <= r_j_qs;
                o_arc_length  <= n_o_len;
            end
        end
    end

    assign o_valid = r_o_valid;

endmodule

`default_nettype wire

// ===== rtl/acr_checker.sv =====
// ----------------------------------------------------------------------------
// acr_checker: port-level checks for the arc-from-chord unit
// Watches handshake and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_center_x,
    input logic signed [31:0] o_center_y,
    input logic signed [15:0] o_entry_angle,
    input logic signed [15:0] o_exit_angle,
    input logic signed [15:0] o_sweep_angle,
    input logic [31:0]        o_arc_length,
    input logic               o_chord_too_long
);

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side stalls exactly when a held result is not taken
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // a stalled result holds its centre, arc length and sweep
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_center_x) && $stable(o_center_y)
            && $stable(o_arc_length) && $stable(o_sweep_angle))
        else $error("stalled result changed");

    // an unreachable centre reports nothing else
    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chord_too_long |-> o_center_x == '0 && o_center_y == '0
            && o_entry_angle == '0 && o_exit_angle == '0 && o_sweep_angle == '0
            && o_arc_length == '0)
        else $error("too-long chord with nonzero result fields");

endmodule

bind arc_from_chord_and_radius_unit acr_checker u_acr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_center_x       (o_center_x),
    .o_center_y       (o_center_y),
    .o_entry_angle    (o_entry_angle),
    .o_exit_angle     (o_exit_angle),
    .o_sweep_angle    (o_sweep_angle),
    .o_arc_length     (o_arc_length),
    .o_chord_too_long (o_chord_too_long)
);

`default_nettype wire
